// ===== rtl/bcc_pkg.sv =====
// Shared constants for the blind corner classifier.
// Holds widths, register indexes and fixed-point constants; no dependencies.
package bcc_pkg;

  localparam int COORD_WIDTH   = 32;
  localparam int DIR_WIDTH     = 16;
  localparam int CFG_IDX_WIDTH = 4;
  localparam int QUEUE_DEPTH   = 4;

  localparam logic [CFG_IDX_WIDTH-1:0] REG_VEHICLE_X  = CFG_IDX_WIDTH'(0);
  localparam logic [CFG_IDX_WIDTH-1:0] REG_VEHICLE_Y  = CFG_IDX_WIDTH'(1);
  localparam logic [CFG_IDX_WIDTH-1:0] REG_HEADING_C  = CFG_IDX_WIDTH'(2);
  localparam logic [CFG_IDX_WIDTH-1:0] REG_HEADING_S  = CFG_IDX_WIDTH'(3);

  localparam logic signed [DIR_WIDTH-1:0] HEADING_ONE = 16'sd16384;

  localparam int NORM_MSB   = 29;
  localparam int NORM_BITS  = 30;
  localparam int ROOT_BITS  = 31;
  localparam int QUOT_BITS  = 15;
  localparam int FRAC_SHIFT = 14;

endpackage

// ===== rtl/bcc_in_if.sv =====
// Input channel of the blind corner classifier: one corner with its neighbours.
// Depends on bcc_pkg for the default coordinate width.
interface bcc_in_if #(parameter int W = bcc_pkg::COORD_WIDTH);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] corner_x;
  logic signed [W-1:0] corner_y;
  logic signed [W-1:0] corner_z;
  logic signed [W-1:0] prev_x;
  logic signed [W-1:0] prev_y;
  logic signed [W-1:0] next_x;
  logic signed [W-1:0] next_y;
  modport source (output valid, corner_x, corner_y, corner_z, prev_x, prev_y, next_x, next_y,
                  input ready);
  modport sink (input valid, corner_x, corner_y, corner_z, prev_x, prev_y, next_x, next_y,
                output ready);
endinterface

// ===== rtl/bcc_out_if.sv =====
// Output channel of the blind corner classifier: one blind corner with its direction.
// Depends on bcc_pkg for the default widths.
interface bcc_out_if #(parameter int W = bcc_pkg::COORD_WIDTH);
  logic                                  valid;
  logic                                  ready;
  logic signed [W-1:0]                   out_x;
  logic signed [W-1:0]                   out_y;
  logic signed [W-1:0]                   out_z;
  logic signed [bcc_pkg::DIR_WIDTH-1:0]  rush_x;
  logic signed [bcc_pkg::DIR_WIDTH-1:0]  rush_y;
  logic                                  on_left;
  modport source (output valid, out_x, out_y, out_z, rush_x, rush_y, on_left, input ready);
  modport sink (input valid, out_x, out_y, out_z, rush_x, rush_y, on_left, output ready);
endinterface

// ===== rtl/bcc_cfg_if.sv =====
// Configuration write channel of the blind corner classifier.
// Depends on bcc_pkg for the default widths.
interface bcc_cfg_if #(parameter int W = bcc_pkg::COORD_WIDTH);
  logic                                  valid;
  logic                                  ready;
  logic [bcc_pkg::CFG_IDX_WIDTH-1:0]     addr;
  logic [W-1:0]                          data;
  modport source (output valid, addr, data, input ready);
  modport sink (input valid, addr, data, output ready);
endinterface

// ===== rtl/bcc_front.sv =====
// Front end: edge and line differences, exact cross products and the corner decision.
// Depends on bcc_pkg and bcc_in_if; pushes kept corners into bcc_queue.
module bcc_front #(
  parameter int W  = bcc_pkg::COORD_WIDTH,
  parameter int QW = 2 * (W + 1) + 3 * W + 1
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  bcc_in_if.sink                               in_i,
  input  logic signed [W-1:0]                  vehicle_x_i,
  input  logic signed [W-1:0]                  vehicle_y_i,
  input  logic signed [bcc_pkg::DIR_WIDTH-1:0] heading_cos_i,
  input  logic signed [bcc_pkg::DIR_WIDTH-1:0] heading_sin_i,
  input  logic                                 full_i,
  output logic                                 push_o,
  output logic [QW-1:0]                        data_o
);
  import bcc_pkg::*;

  localparam int DW = W + 1;
  localparam int PW = 2 * DW;
  localparam int HW = DW + DIR_WIDTH;

  logic en;
  logic v1_q, v2_q, v3_q;

  logic signed [DW-1:0] lx1_q, ly1_q, e1x1_q, e1y1_q, e2x1_q, e2y1_q;
  logic signed [DIR_WIDTH-1:0] hc1_q, hs1_q;
  logic signed [W-1:0] x1_q, y1_q, z1_q;

  logic signed [PW-1:0] pdet_a_q, pdet_b_q, pa_a_q, pa_b_q, pb_a_q, pb_b_q, pd_a_q, pd_b_q;
  logic signed [HW-1:0] pf_a_q, pf_b_q, pl_a_q, pl_b_q;
  logic signed [DW-1:0] e1x2_q, e1y2_q, e2x2_q, e2y2_q;
  logic signed [W-1:0] x2_q, y2_q, z2_q;

  logic signed [PW:0] det_s, sa_s, sb_s, dot_s;
  logic signed [HW:0] fwd_s, left_s;
  logic dp, dn, ap, an, bp, bn, in_cone, keep;

  logic keep3_q, left3_q;
  logic signed [DW-1:0] ex3_q, ey3_q;
  logic signed [W-1:0] x3_q, y3_q, z3_q;

  assign en = !(v3_q && keep3_q && full_i);
  assign in_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_i.valid;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      lx1_q  <= DW'(in_i.corner_x) - DW'(vehicle_x_i);
      ly1_q  <= DW'(in_i.corner_y) - DW'(vehicle_y_i);
      e1x1_q <= DW'(in_i.next_x) - DW'(in_i.corner_x);
      e1y1_q <= DW'(in_i.next_y) - DW'(in_i.corner_y);
      e2x1_q <= DW'(in_i.prev_x) - DW'(in_i.corner_x);
      e2y1_q <= DW'(in_i.prev_y) - DW'(in_i.corner_y);
      hc1_q  <= heading_cos_i;
      hs1_q  <= heading_sin_i;
      x1_q   <= in_i.corner_x;
      y1_q   <= in_i.corner_y;
      z1_q   <= in_i.corner_z;

      pdet_a_q <= PW'(e1x1_q) * PW'(e2y1_q);
      pdet_b_q <= PW'(e1y1_q) * PW'(e2x1_q);
      pa_a_q   <= PW'(lx1_q) * PW'(e2y1_q);
      pa_b_q   <= PW'(ly1_q) * PW'(e2x1_q);
      pb_a_q   <= PW'(e1x1_q) * PW'(ly1_q);
      pb_b_q   <= PW'(e1y1_q) * PW'(lx1_q);
      pd_a_q   <= PW'(e1x1_q) * PW'(lx1_q);
      pd_b_q   <= PW'(e1y1_q) * PW'(ly1_q);
      pf_a_q   <= HW'(lx1_q) * HW'(hc1_q);
      pf_b_q   <= HW'(ly1_q) * HW'(hs1_q);
      pl_a_q   <= HW'(lx1_q) * HW'(hs1_q);
      pl_b_q   <= HW'(ly1_q) * HW'(hc1_q);
      e1x2_q   <= e1x1_q;
      e1y2_q   <= e1y1_q;
      e2x2_q   <= e2x1_q;
      e2y2_q   <= e2y1_q;
      x2_q     <= x1_q;
      y2_q     <= y1_q;
      z2_q     <= z1_q;

      keep3_q <= keep;
      left3_q <= !left_s[HW];
      ex3_q   <= (dot_s > 0) ? e1x2_q : e2x2_q;
      ey3_q   <= (dot_s > 0) ? e1y2_q : e2y2_q;
      x3_q    <= x2_q;
      y3_q    <= y2_q;
      z3_q    <= z2_q;
    end
  end

  always_comb begin
    det_s  = (PW + 1)'(pdet_a_q) - (PW + 1)'(pdet_b_q);
    sa_s   = (PW + 1)'(pa_a_q) - (PW + 1)'(pa_b_q);
    sb_s   = (PW + 1)'(pb_a_q) - (PW + 1)'(pb_b_q);
    dot_s  = (PW + 1)'(pd_a_q) + (PW + 1)'(pd_b_q);
    fwd_s  = (HW + 1)'(pf_a_q) + (HW + 1)'(pf_b_q);
    left_s = (HW + 1)'(pl_b_q) - (HW + 1)'(pl_a_q);
    dn = det_s[PW];
    dp = !det_s[PW] && (det_s != '0);
    an = sa_s[PW];
    ap = !sa_s[PW] && (sa_s != '0);
    bn = sb_s[PW];
    bp = !sb_s[PW] && (sb_s != '0);
    in_cone = (dp || dn) && ((ap && bp) || (an && bn));
    keep = !in_cone && (fwd_s > 0);
  end

  assign push_o = v3_q && keep3_q && !full_i;
  assign data_o = {ex3_q, ey3_q, x3_q, y3_q, z3_q, left3_q};

endmodule

// ===== rtl/bcc_queue.sv =====
// Short word queue between the front and back ends of the classifier.
// Depends on bcc_pkg for its depth.
module bcc_queue #(
  parameter int QW    = 8,
  parameter int DEPTH = bcc_pkg::QUEUE_DEPTH
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  logic [QW-1:0] data_i,
  input  logic          pop_i,
  output logic          full_o,
  output logic          empty_o,
  output logic [QW-1:0] data_o
);
  import bcc_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [QW-1:0] mem_q [DEPTH];
  logic [AW-1:0] wr_q, rd_q;
  logic [AW:0]   cnt_q;

  assign full_o  = (cnt_q == (AW + 1)'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + AW'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + AW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + (AW + 1)'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - (AW + 1)'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

// ===== rtl/bcc_back.sv =====
// Back end: normalises the chosen edge into a Q2.14 unit rush-out direction.
// Depends on bcc_pkg and bcc_out_if; pops words from bcc_queue.
module bcc_back #(
  parameter int W  = bcc_pkg::COORD_WIDTH,
  parameter int QW = 2 * (W + 1) + 3 * W + 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          empty_i,
  input  logic [QW-1:0] data_i,
  output logic          pop_o,
  bcc_out_if.source     out_o
);
  import bcc_pkg::*;

  localparam int DW  = W + 1;
  localparam int PBW = $clog2(DW);
  localparam int SQW = 2 * ROOT_BITS + 1;
  localparam int NW  = NORM_BITS + FRAC_SHIFT + 2;

  typedef struct packed {
    logic signed [W-1:0] x;
    logic signed [W-1:0] y;
    logic signed [W-1:0] z;
    logic                left;
    logic                zero;
    logic                posx;
    logic                posy;
  } carry_t;

  logic en;
  logic signed [DW-1:0] ex, ey;
  carry_t cin;

  logic v0_q, v1_q, v2_q, v3_q;
  carry_t c0_q, c1_q, c2_q, c3_q;
  logic [DW-1:0] ax0_q, ay0_q, ax1_q, ay1_q;
  logic [PBW-1:0] p1_q;
  logic [NORM_BITS-1:0] nx2_q, ny2_q, nx3_q, ny3_q;
  logic [SQW-1:0] n3_q;
  logic [DW-1:0] mx;
  logic [PBW-1:0] msb;
  logic [DW+31:0] wx, wy;

  logic                 sv_q   [1:ROOT_BITS];
  carry_t               sc_q   [1:ROOT_BITS];
  logic [SQW-1:0]       srem_q [1:ROOT_BITS];
  logic [ROOT_BITS-1:0] sroot_q[1:ROOT_BITS];
  logic [NORM_BITS-1:0] snx_q  [1:ROOT_BITS];
  logic [NORM_BITS-1:0] sny_q  [1:ROOT_BITS];

  logic                 dv_q  [QUOT_BITS+1];
  carry_t               dc_q  [QUOT_BITS+1];
  logic [NW-1:0]        drx_q [QUOT_BITS+1];
  logic [NW-1:0]        dry_q [QUOT_BITS+1];
  logic [QUOT_BITS-1:0] dqx_q [QUOT_BITS+1];
  logic [QUOT_BITS-1:0] dqy_q [QUOT_BITS+1];
  logic [ROOT_BITS-1:0] dr_q  [QUOT_BITS+1];

  logic out_v_q;
  carry_t oc_q;
  logic signed [DIR_WIDTH-1:0] rx_q, ry_q;
  logic [DIR_WIDTH-1:0] qxe, qye;

  assign en    = !out_v_q || out_o.ready;
  assign pop_o = en && !empty_i;

  always_comb begin
    {ex, ey, cin.x, cin.y, cin.z, cin.left} = data_i;
    cin.posx = !ex[DW-1] && (ex != '0);
    cin.posy = !ey[DW-1] && (ey != '0);
    cin.zero = (ex == '0) && (ey == '0);
  end

  always_comb begin
    mx  = (ax0_q > ay0_q) ? ax0_q : ay0_q;
    msb = '0;
    for (int i = 0; i < DW; i++) begin
      if (mx[i]) begin
        msb = PBW'(i);
      end
    end
  end

  always_comb begin
    if (int'(p1_q) >= NORM_MSB) begin
      wx = {32'b0, ax1_q} >> (int'(p1_q) - NORM_MSB);
      wy = {32'b0, ay1_q} >> (int'(p1_q) - NORM_MSB);
    end else begin
      wx = {32'b0, ax1_q} << (NORM_MSB - int'(p1_q));
      wy = {32'b0, ay1_q} << (NORM_MSB - int'(p1_q));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en) begin
      v0_q <= !empty_i;
      v1_q <= v0_q;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c0_q  <= cin;
      ax0_q <= ex[DW-1] ? DW'(-ex) : DW'(ex);
      ay0_q <= ey[DW-1] ? DW'(-ey) : DW'(ey);
      c1_q  <= c0_q;
      ax1_q <= ax0_q;
      ay1_q <= ay0_q;
      p1_q  <= msb;
      c2_q  <= c1_q;
      nx2_q <= wx[NORM_BITS-1:0];
      ny2_q <= wy[NORM_BITS-1:0];
      c3_q  <= c2_q;
      nx3_q <= nx2_q;
      ny3_q <= ny2_q;
      n3_q  <= SQW'(nx2_q) * SQW'(nx2_q) + SQW'(ny2_q) * SQW'(ny2_q);
    end
  end

  for (genvar k = 0; k < ROOT_BITS; k++) begin : g_sqrt
    localparam int B = ROOT_BITS - 1 - k;
    logic                 iv;
    carry_t               ic;
    logic [SQW-1:0]       irem;
    logic [ROOT_BITS-1:0] iroot;
    logic [NORM_BITS-1:0] inx, iny;
    logic [SQW-1:0]       t;
    logic                 ge;
    if (k == 0) begin : g_head
      assign iv    = v3_q;
      assign ic    = c3_q;
      assign irem  = n3_q;
      assign iroot = '0;
      assign inx   = nx3_q;
      assign iny   = ny3_q;
    end else begin : g_body
      assign iv    = sv_q[k];
      assign ic    = sc_q[k];
      assign irem  = srem_q[k];
      assign iroot = sroot_q[k];
      assign inx   = snx_q[k];
      assign iny   = sny_q[k];
    end
    always_comb begin
      t  = (SQW'(iroot) << (B + 1)) + (SQW'(1) << (2 * B));
      ge = irem >= t;
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sv_q[k+1] <= 1'b0;
      end else if (en) begin
        sv_q[k+1] <= iv;
      end
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        sc_q[k+1]    <= ic;
        snx_q[k+1]   <= inx;
        sny_q[k+1]   <= iny;
        srem_q[k+1]  <= ge ? irem - t : irem;
        sroot_q[k+1] <= ge ? (iroot | (ROOT_BITS'(1) << B)) : iroot;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_q[0] <= 1'b0;
    end else if (en) begin
      dv_q[0] <= sv_q[ROOT_BITS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dc_q[0]  <= sc_q[ROOT_BITS];
      dr_q[0]  <= sroot_q[ROOT_BITS];
      drx_q[0] <= (NW'(snx_q[ROOT_BITS]) << FRAC_SHIFT) + NW'(sroot_q[ROOT_BITS] >> 1);
      dry_q[0] <= (NW'(sny_q[ROOT_BITS]) << FRAC_SHIFT) + NW'(sroot_q[ROOT_BITS] >> 1);
      dqx_q[0] <= '0;
      dqy_q[0] <= '0;
    end
  end

  for (genvar k = 0; k < QUOT_BITS; k++) begin : g_div
    localparam int B = QUOT_BITS - 1 - k;
    logic [NW-1:0] d;
    logic          gx, gy;
    always_comb begin
      d  = NW'(dr_q[k]) << B;
      gx = drx_q[k] >= d;
      gy = dry_q[k] >= d;
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[k+1] <= 1'b0;
      end else if (en) begin
        dv_q[k+1] <= dv_q[k];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        dc_q[k+1]  <= dc_q[k];
        dr_q[k+1]  <= dr_q[k];
        drx_q[k+1] <= gx ? drx_q[k] - d : drx_q[k];
        dry_q[k+1] <= gy ? dry_q[k] - d : dry_q[k];
        dqx_q[k+1] <= gx ? (dqx_q[k] | (QUOT_BITS'(1) << B)) : dqx_q[k];
        dqy_q[k+1] <= gy ? (dqy_q[k] | (QUOT_BITS'(1) << B)) : dqy_q[k];
      end
    end
  end

  assign qxe = DIR_WIDTH'(dqx_q[QUOT_BITS]);
  assign qye = DIR_WIDTH'(dqy_q[QUOT_BITS]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= dv_q[QUOT_BITS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      oc_q <= dc_q[QUOT_BITS];
      if (dc_q[QUOT_BITS].zero) begin
        rx_q <= '0;
        ry_q <= '0;
      end else begin
        rx_q <= dc_q[QUOT_BITS].posx ? -qxe : qxe;
        ry_q <= dc_q[QUOT_BITS].posy ? -qye : qye;
      end
    end
  end

  assign out_o.valid   = out_v_q;
  assign out_o.out_x   = oc_q.x;
  assign out_o.out_y   = oc_q.y;
  assign out_o.out_z   = oc_q.z;
  assign out_o.rush_x  = rx_q;
  assign out_o.rush_y  = ry_q;
  assign out_o.on_left = oc_q.left;

endmodule

// ===== rtl/blind_corner_classifier.sv =====
// Top level of the blind corner classifier.
// Depends on bcc_pkg, the three channel interfaces, bcc_front, bcc_queue and bcc_back.
//
// Usage: the host writes vehicle_x, vehicle_y, heading_cos and heading_sin through
// cfg_i (addresses 0 to 3, other addresses ignored) while the block is idle; the
// configuration channel is always ready. Each word on in_i is one wall corner with
// its previous and next ring neighbours. A corner that is a forward-facing blind
// corner produces one word on out_o; other corners produce nothing.
// Throughput is one corner per cycle unless a full queue stalls the front end. A
// corner passes through three front stages of differences, exact products and sign
// tests, then the queue, then a 52-stage back end dominated by the 31 square-root
// stages and the 15 restoring division stages.
// Reset clears all valid flags and the queue, and sets the vehicle to the origin
// facing along x. When out_o is stalled the back end holds, the four-word queue
// absorbs front-end words, and in_i drops ready once the queue is full and a kept
// word waits at the end of the front end.
module blind_corner_classifier #(
  parameter int COORD_WIDTH = bcc_pkg::COORD_WIDTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  bcc_in_if.sink     in_i,
  bcc_out_if.source  out_o,
  bcc_cfg_if.sink    cfg_i
);
  import bcc_pkg::*;

  localparam int QW = 2 * (COORD_WIDTH + 1) + 3 * COORD_WIDTH + 1;

  logic signed [COORD_WIDTH-1:0] vx_q, vy_q;
  logic signed [DIR_WIDTH-1:0]   hc_q, hs_q;
  logic                          push, pop, full, empty;
  logic [QW-1:0]                 qin, qout;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vx_q <= '0;
      vy_q <= '0;
      hc_q <= HEADING_ONE;
      hs_q <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_i.addr)
        REG_VEHICLE_X: vx_q <= cfg_i.data;
        REG_VEHICLE_Y: vy_q <= cfg_i.data;
        REG_HEADING_C: hc_q <= cfg_i.data[DIR_WIDTH-1:0];
        REG_HEADING_S: hs_q <= cfg_i.data[DIR_WIDTH-1:0];
        default: begin
        end
      endcase
    end
  end

  bcc_front #(.W(COORD_WIDTH), .QW(QW)) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_i          (in_i),
    .vehicle_x_i   (vx_q),
    .vehicle_y_i   (vy_q),
    .heading_cos_i (hc_q),
    .heading_sin_i (hs_q),
    .full_i        (full),
    .push_o        (push),
    .data_o        (qin)
  );

  bcc_queue #(.QW(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (qin),
    .pop_i   (pop),
    .full_o  (full),
    .empty_o (empty),
    .data_o  (qout)
  );

  bcc_back #(.W(COORD_WIDTH), .QW(QW)) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (empty),
    .data_i  (qout),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule

// ===== tb/sv/blind_corner_classifier_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for blind_corner_classifier: random and directed corners
// are checked word by word against an in-bench predictor of the classification.
// Depends on bcc_pkg, the three channel interfaces and the block itself.
module blind_corner_classifier_tb;
  import bcc_pkg::*;

  localparam logic [CFG_IDX_WIDTH-1:0] REG_SPARE_FIRST = REG_HEADING_S + CFG_IDX_WIDTH'(1);
  localparam logic [CFG_IDX_WIDTH-1:0] REG_SPARE_LAST  = '1;

  typedef struct {
    logic signed [COORD_WIDTH-1:0] cx, cy, cz, px, py, nx, ny;
    bit                            drain;
  } corner_t;

  typedef struct {
    logic signed [COORD_WIDTH-1:0] x, y, z;
    logic [DIR_WIDTH-1:0]          rx, ry;
    logic                          left;
  } blind_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  always #4 clk_i = ~clk_i;

  bcc_in_if  in_if ();
  bcc_out_if out_if ();
  bcc_cfg_if cfg_if ();

  blind_corner_classifier dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  logic signed [COORD_WIDTH-1:0] pose_x, pose_y;
  logic signed [DIR_WIDTH-1:0]   head_c, head_s;

  corner_t corner_q[$];
  blind_t  blind_q[$];
  corner_t cur_corner;
  int      errors = 0;
  int      n_accepted = 0;
  int      send_gap = 0;
  int      recv_gap = 0;
  bit      burst = 1'b0;
  bit      hold_active = 1'b0;
  bit      hold_done = 1'b0;
  int      hold_cnt = 0;
  int      cycles = 0;

  function automatic void queue_corner(input corner_t c);
    corner_q.insert(corner_q.size(), c);
  endfunction

  function automatic void queue_blind(input blind_t b);
    blind_q.insert(blind_q.size(), b);
  endfunction

  function automatic int sign_of(input logic signed [33:0] a, b, c, d);
    logic signed [71:0] s;
    s = 72'(a) * 72'(b) + 72'(c) * 72'(d);
    return (s < 0) ? -1 : ((s == 0) ? 0 : 1);
  endfunction

  function automatic logic [63:0] root_floor(input logic [63:0] n);
    logic [63:0] res, bit_v;
    res = 0;
    bit_v = 64'd1 << 62;
    while (bit_v > n) bit_v = bit_v >> 2;
    while (bit_v != 0) begin
      if (n >= res + bit_v) begin
        n = n - (res + bit_v);
        res = (res >> 1) + bit_v;
      end else begin
        res = res >> 1;
      end
      bit_v = bit_v >> 2;
    end
    return res;
  endfunction

  function automatic void rush_of(input logic signed [33:0] ex, ey,
                                  output logic [15:0] rx, ry);
    logic [63:0] ax, ay, m, r, qx, qy;
    ax = (ex < 0) ? 64'(-ex) : 64'(ex);
    ay = (ey < 0) ? 64'(-ey) : 64'(ey);
    m = (ax > ay) ? ax : ay;
    if (m == 0) begin
      rx = 0;
      ry = 0;
      return;
    end
    while (m >= (64'd1 << 30)) begin
      m = m >> 1; ax = ax >> 1; ay = ay >> 1;
    end
    while (m < (64'd1 << 29)) begin
      m = m << 1; ax = ax << 1; ay = ay << 1;
    end
    r = root_floor(ax * ax + ay * ay);
    qx = (ax * 64'd16384 + r / 2) / r;
    qy = (ay * 64'd16384 + r / 2) / r;
    rx = (ex > 0) ? 16'(-qx) : 16'(qx);
    ry = (ey > 0) ? 16'(-qy) : 16'(qy);
  endfunction

  function automatic bit classify(input corner_t c, output blind_t b);
    logic signed [33:0] lx, ly, e1x, e1y, e2x, e2y, hc, hs;
    int det, sa, sb;
    bit in_cone;
    lx = 34'(c.cx) - 34'(pose_x);
    ly = 34'(c.cy) - 34'(pose_y);
    e1x = 34'(c.nx) - 34'(c.cx);
    e1y = 34'(c.ny) - 34'(c.cy);
    e2x = 34'(c.px) - 34'(c.cx);
    e2y = 34'(c.py) - 34'(c.cy);
    hc = 34'(head_c);
    hs = 34'(head_s);
    det = sign_of(e1x, e2y, -e1y, e2x);
    sa = sign_of(lx, e2y, -ly, e2x);
    sb = sign_of(e1x, ly, -e1y, lx);
    in_cone = det != 0 && ((sa == det && sb == det) || (sa == -det && sb == -det));
    if (in_cone || sign_of(lx, hc, ly, hs) <= 0) return 1'b0;
    if (sign_of(e1x, lx, e1y, ly) > 0) rush_of(e1x, e1y, b.rx, b.ry);
    else rush_of(e2x, e2y, b.rx, b.ry);
    b.x = c.cx;
    b.y = c.cy;
    b.z = c.cz;
    b.left = sign_of(-hs, lx, hc, ly) >= 0;
    return 1'b1;
  endfunction

  function automatic logic signed [31:0] rand_span(input int bits);
    return 32'($urandom_range(0, (32'd1 << bits) - 1)) - (32'sd1 << (bits - 1));
  endfunction

  function automatic corner_t make_corner();
    corner_t c;
    int kind, sz;
    kind = $urandom_range(0, 99);
    sz = $urandom_range(2, 30);
    c.drain = 1'b0;
    c.cz = $urandom;
    if (kind < 20) begin
      c.cx = $urandom; c.cy = $urandom; c.px = $urandom;
      c.py = $urandom; c.nx = $urandom; c.ny = $urandom;
    end else begin
      c.cx = pose_x + rand_span(sz);
      c.cy = pose_y + rand_span(sz);
      c.px = c.cx + rand_span(sz);
      c.py = c.cy + rand_span(sz);
      c.nx = c.cx + rand_span(sz);
      c.ny = c.cy + rand_span(sz);
      if (kind < 26) begin
        c.nx = c.cx; c.ny = c.cy;
      end else if (kind < 31) begin
        c.px = c.cx; c.py = c.cy;
      end else if (kind < 37) begin
        c.px = c.cx - (c.nx - c.cx);
        c.py = c.cy - (c.ny - c.cy);
      end else if (kind < 40) begin
        c.cx = pose_x; c.cy = pose_y;
      end
    end
    return c;
  endfunction

  function automatic corner_t fixed_corner(input logic signed [31:0] cx, cy, px, py, nx, ny);
    corner_t c;
    c.cx = cx; c.cy = cy; c.cz = $urandom;
    c.px = px; c.py = py; c.nx = nx; c.ny = ny;
    c.drain = 1'b0;
    return c;
  endfunction

  // Input driver: takes the next corner from the queue once the current word has gone.
  always @(posedge clk_i) begin
    blind_t b;
    if (!in_if.valid || in_if.ready) begin
      if (in_if.valid) begin
        n_accepted <= n_accepted + 1;
        if (classify(cur_corner, b)) queue_blind(b);
      end
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_if.valid <= 1'b0;
      end else if (corner_q.size() > 0 &&
                   !(corner_q[0].drain && (blind_q.size() > 0 || in_if.valid))) begin
        cur_corner = corner_q.pop_front();
        in_if.corner_x <= cur_corner.cx;
        in_if.corner_y <= cur_corner.cy;
        in_if.corner_z <= cur_corner.cz;
        in_if.prev_x <= cur_corner.px;
        in_if.prev_y <= cur_corner.py;
        in_if.next_x <= cur_corner.nx;
        in_if.next_y <= cur_corner.ny;
        in_if.valid <= 1'b1;
        send_gap <= burst ? 0 : $urandom_range(0, 15);
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Long hold-off of the receiver, so that the queue fills and the input stalls.
  always @(posedge clk_i) begin
    if (!hold_done && !hold_active && n_accepted >= 300) begin
      hold_active <= 1'b1;
      hold_cnt <= 400;
    end else if (hold_active) begin
      if (hold_cnt == 0) begin
        hold_active <= 1'b0;
        hold_done <= 1'b1;
      end else begin
        hold_cnt <= hold_cnt - 1;
      end
    end
  end

  // Output monitor: checks each accepted word against the oldest prediction.
  always @(posedge clk_i) begin
    blind_t e;
    bit stall;
    int gap;
    stall = 1'b0;
    if (out_if.valid && out_if.ready) begin
      stall = 1'b1;
      if (blind_q.size() == 0) begin
        $display("%0t: unexpected word x=%0d y=%0d", $time, out_if.out_x, out_if.out_y);
        errors++;
      end else begin
        e = blind_q.pop_front();
        if (out_if.out_x !== e.x) begin
          $display("%0t: out_x exp %0d act %0d", $time, e.x, out_if.out_x); errors++;
        end
        if (out_if.out_y !== e.y) begin
          $display("%0t: out_y exp %0d act %0d", $time, e.y, out_if.out_y); errors++;
        end
        if (out_if.out_z !== e.z) begin
          $display("%0t: out_z exp %0d act %0d", $time, e.z, out_if.out_z); errors++;
        end
        if (out_if.rush_x !== e.rx) begin
          $display("%0t: rush_x exp %h act %h", $time, e.rx, out_if.rush_x); errors++;
        end
        if (out_if.rush_y !== e.ry) begin
          $display("%0t: rush_y exp %h act %h", $time, e.ry, out_if.rush_y); errors++;
        end
        if (out_if.on_left !== e.left) begin
          $display("%0t: on_left exp %b act %b", $time, e.left, out_if.on_left); errors++;
        end
      end
    end
    if (hold_active) begin
      out_if.ready <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap <= recv_gap - 1;
      out_if.ready <= 1'b0;
    end else if (stall && !burst) begin
      gap = $urandom_range(0, 15);
      recv_gap <= (gap > 0) ? gap - 1 : 0;
      out_if.ready <= (gap == 0);
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 600000) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_WIDTH-1:0] idx, input logic [31:0] value);
    @(posedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.addr <= idx;
    cfg_if.data <= value;
    do @(posedge clk_i); while (!cfg_if.ready);
    case (idx)
      REG_VEHICLE_X: pose_x = value;
      REG_VEHICLE_Y: pose_y = value;
      REG_HEADING_C: head_c = value[15:0];
      REG_HEADING_S: head_s = value[15:0];
      default: ;
    endcase
    cfg_if.valid <= 1'b0;
  endtask

  task automatic drain_all();
    while (corner_q.size() > 0 || in_if.valid || blind_q.size() > 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  task automatic set_pose(input logic [31:0] x, y, input logic [15:0] c, s);
    write_reg(REG_VEHICLE_X, x);
    write_reg(REG_VEHICLE_Y, y);
    write_reg(REG_HEADING_C, {16'h0, c});
    write_reg(REG_HEADING_S, {16'h0, s});
  endtask

  task automatic random_phase(input int count, input bit fast);
    corner_t c;
    burst = fast;
    for (int i = 0; i < count; i++) begin
      c = make_corner();
      if (i == count / 2) c.drain = 1'b1;
      queue_corner(c);
    end
    drain_all();
  endtask

  initial begin
    in_if.valid = 1'b0;
    in_if.corner_x = '0; in_if.corner_y = '0; in_if.corner_z = '0;
    in_if.prev_x = '0; in_if.prev_y = '0; in_if.next_x = '0; in_if.next_y = '0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.addr = '0;
    cfg_if.data = '0;
    pose_x = 0; pose_y = 0; head_c = HEADING_ONE; head_s = 0;
    rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    queue_corner(fixed_corner(32'sd65536, 0, 32'sd65536, 32'sd65536,
                              32'sd131072, 0));
    queue_corner(fixed_corner(32'sd65536, 32'sd65536, 32'sd65536, 32'sd65536,
                              32'sd131072, 0));
    queue_corner(fixed_corner(32'sd65536, 0, 32'sd65536, 32'sd65536,
                              32'sd65536, 0));
    queue_corner(fixed_corner(32'sd65536, 0, 0, 0, 32'sd131072, 0));
    queue_corner(fixed_corner(32'sd65536, 0, 32'sd131072, 32'sd65536,
                              32'sd131072, -32'sd65536));
    queue_corner(fixed_corner(0, 0, 32'sd65536, 32'sd65536, 32'sd65536, 0));
    queue_corner(fixed_corner(-32'sd65536, 0, 0, 32'sd65536, 0, 0));
    queue_corner(fixed_corner(32'sd65536, 32'sd65536, 32'sd65536, 0, 0,
                              32'sd65536));
    queue_corner(fixed_corner(32'sd65536, -32'sd65536, 32'sd65536, 0, 0,
                              -32'sd65536));
    queue_corner(fixed_corner(32'sh7fffffff, 32'sh7fffffff, 32'sh80000000,
                              32'sh80000000, 32'sh80000000, 32'sh7fffffff));
    queue_corner(fixed_corner(32'sh7fffffff, 32'sh80000000, 32'sh80000000,
                              32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff));
    queue_corner(fixed_corner(32'sh7fffffff, 0, 32'sh80000000, 0,
                              32'sh7fffffff, 0));
    queue_corner(fixed_corner(1, 0, 2, 1, 2, -1));
    queue_corner(fixed_corner(1, 0, 1, 1, 1, -1));
    queue_corner(fixed_corner(32'sd100, 32'sd5, 32'sd100, 32'sd5, 32'sd100, 32'sd5));
    queue_corner(fixed_corner(32'sd65536, 0, 32'sd65537, 32'sh7fffffff,
                              32'sd65536, 32'sh80000000));
    queue_corner(fixed_corner(32'sd3, 32'sd4, 32'sd6, 32'sd8, 0, 0));
    queue_corner(fixed_corner(32'sd1000, -32'sd7, 32'sd900, 32'sd50, 32'sd1100,
                              32'sd40));
    drain_all();

    random_phase(120, 1'b0);
    write_reg(REG_SPARE_FIRST, 32'hffffffff);
    write_reg(REG_SPARE_LAST, 32'h12345678);
    set_pose(32'h80000000, 32'h7fffffff, 16'hc000, 16'h0000);
    random_phase(90, 1'b0);
    set_pose(32'h7fffffff, 32'h80000000, 16'h0000, 16'h4000);
    random_phase(90, 1'b1);
    set_pose($urandom, $urandom, 16'h0000, 16'hc000);
    random_phase(90, 1'b0);
    set_pose($urandom, $urandom, 16'h8000, 16'h7fff);
    random_phase(90, 1'b0);
    set_pose($urandom, $urandom, 16'h7fff, 16'h8000);
    random_phase(90, 1'b1);
    set_pose($urandom_range(0, 32'hfffff), $urandom_range(0, 32'hfffff),
             16'h2d41, 16'hd2bf);
    random_phase(90, 1'b0);
    set_pose($urandom, $urandom, 16'($urandom), 16'($urandom));
    random_phase(90, 1'b0);

    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule

// ===== files.f =====
rtl/bcc_pkg.sv
rtl/bcc_in_if.sv
rtl/bcc_out_if.sv
rtl/bcc_cfg_if.sv
rtl/bcc_front.sv
rtl/bcc_queue.sv
rtl/bcc_back.sv
rtl/blind_corner_classifier.sv
tb/sv/blind_corner_classifier_tb.sv
